/* hdl/eco_pkg.sv */
// Shared codes and types for the easing curve evaluator.
`timescale 1ns / 1ps

package eco_pkg;

   // Default number of fraction bits of the Q1.F progress and result.
   localparam int FRAC_BITS_DEFAULT = 16;

   // Curve selector codes.
   localparam logic [2:0] FUNC_CUBIC_IN     = 3'd0;
   localparam logic [2:0] FUNC_CUBIC_OUT    = 3'd1;
   localparam logic [2:0] FUNC_CUBIC_IN_OUT = 3'd2;
   localparam logic [2:0] FUNC_BOUNCE_OUT   = 3'd3;
   localparam logic [2:0] FUNC_BOUNCE_IN    = 3'd4;

   // Bounce segment, in order of rising progress.
   typedef enum logic [1:0] {
      PIECE_FIRST,
      PIECE_SECOND,
      PIECE_THIRD,
      PIECE_FOURTH
   } piece_type;

   // Control that travels alongside the datapath.
   typedef struct packed {
      logic [2:0] func;
      logic       hi;     // cubic in-out: progress at or above one half
      piece_type  piece;
   } ctl_type;

endpackage

/* hdl/easing_curve_evaluator.sv */
// Top level of the easing curve evaluator: four-stage pipeline.
//
//  channel   dir  payload                        handshake
//  -------   ---  -----------------------------  -----------------------
//  request   in   req_func[2:0], req_t[F:0]      req_valid / req_ready
//  response  out  rsp_eased[F:0]                 rsp_valid / rsp_ready
//
//  One request per clock while no stage is stalled; each request that is taken
//  passes through the four register stages (prepare, square, cube, select).
//  Reset clears only the stage valid bits; the datapath registers keep junk.
//  Each stage holds while the stage after it is full and stalled, and takes
//  new data as soon as it empties, so bubbles close up under back-pressure.
`timescale 1ns / 1ps

module easing_curve_evaluator #(
   parameter int FRAC_BITS = eco_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_func,
   input  logic [FRAC_BITS:0]   req_t,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [FRAC_BITS:0]   rsp_eased
);

   // Stage 1 to stage 2
   logic                        s1_valid, s1_ready;
   logic [FRAC_BITS:0]          s1_x;
   logic [FRAC_BITS+1:0]        s1_d;
   eco_pkg::ctl_type            s1_ctl;

   // Stage 2 to stage 3
   logic                        s2_valid, s2_ready;
   logic [FRAC_BITS:0]          s2_x;
   logic [2*FRAC_BITS+1:0]      s2_xx;
   logic [2*FRAC_BITS+3:0]      s2_sq;
   eco_pkg::ctl_type            s2_ctl;

   // Stage 3 to stage 4
   logic                        s3_valid, s3_ready;
   logic [2*FRAC_BITS+1:0]      s3_p;
   logic [FRAC_BITS:0]          s3_bq;
   eco_pkg::ctl_type            s3_ctl;

   // Saturate t, build the cube operand, classify the bounce segment.
   eco_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_func   (req_func),
      .in_t      (req_t),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_x     (s1_x),
      .out_d     (s1_d),
      .out_ctl   (s1_ctl)
   );

   // Both squares in parallel: x*x for the cube, d*d for the bounce.
   eco_square #(.FRAC_BITS(FRAC_BITS)) u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_x      (s1_x),
      .in_d      (s1_d),
      .in_ctl    (s1_ctl),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_x     (s2_x),
      .out_xx    (s2_xx),
      .out_sq    (s2_sq),
      .out_ctl   (s2_ctl)
   );

   // Round the square and take the third factor; finish the bounce value.
   eco_cube #(.FRAC_BITS(FRAC_BITS)) u_cube (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_x      (s2_x),
      .in_xx     (s2_xx),
      .in_sq     (s2_sq),
      .in_ctl    (s2_ctl),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_p     (s3_p),
      .out_bq    (s3_bq),
      .out_ctl   (s3_ctl)
   );

   // Select the curve and hold the result in the output register.
   eco_final #(.FRAC_BITS(FRAC_BITS)) u_final (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_p      (s3_p),
      .in_bq     (s3_bq),
      .in_ctl    (s3_ctl),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_eased (rsp_eased)
   );

endmodule

/* hdl/eco_prep.sv */
// Stage 1: saturate progress, form the cube operand and the bounce distance.
`timescale 1ns / 1ps

module eco_prep #(
   parameter int FRAC_BITS = eco_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [2:0]             in_func,
   input  logic [FRAC_BITS:0]     in_t,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [FRAC_BITS:0]     out_x,
   output logic [FRAC_BITS+1:0]   out_d,
   output eco_pkg::ctl_type       out_ctl
);

   localparam int W  = FRAC_BITS + 1;
   localparam int TW = FRAC_BITS + 5;
   localparam logic [W-1:0]  ONE   = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [TW-1:0] LIM4  = TW'(4) << FRAC_BITS;
   localparam logic [TW-1:0] LIM8  = TW'(8) << FRAC_BITS;
   localparam logic [TW-1:0] LIM10 = TW'(10) << FRAC_BITS;
   localparam logic [TW-1:0] MID1  = TW'(6) << FRAC_BITS;
   localparam logic [TW-1:0] MID2  = TW'(9) << FRAC_BITS;
   localparam logic [TW-1:0] MID3  = TW'(21) << (FRAC_BITS - 1);

   logic                  valid_ff;
   logic [W-1:0]          x_ff, x_in;
   logic [FRAC_BITS+1:0]  d_ff, d_in;
   eco_pkg::ctl_type      ctl_ff, ctl_in;

   logic [W-1:0]          t_sat;
   logic [W-1:0]          t_inv;
   logic [W-1:0]          t_bnc;
   logic [TW-1:0]         t_ext;
   logic [TW-1:0]         t11;
   logic [TW-1:0]         mid;
   logic [TW-1:0]         span;

   always_comb begin
      // Progress above one saturates to one.
      t_sat = (in_t[FRAC_BITS] && (|in_t[FRAC_BITS-1:0])) ? ONE : in_t;
      t_inv = ONE - t_sat;

      ctl_in.func = in_func;
      ctl_in.hi   = t_sat[FRAC_BITS] | t_sat[FRAC_BITS-1];

      case (in_func)
         eco_pkg::FUNC_CUBIC_OUT: begin
            x_in = t_inv;
         end
         eco_pkg::FUNC_CUBIC_IN_OUT: begin
            // Upper half: u = 2 - 2t, which stays within one.
            x_in = ctl_in.hi ? {t_inv[W-2:0], 1'b0} : t_sat;
         end
         default: begin
            x_in = t_sat;
         end
      endcase

      t_bnc = (in_func == eco_pkg::FUNC_BOUNCE_IN) ? t_inv : t_sat;
      t_ext = TW'(t_bnc);
      t11   = (t_ext << 3) + (t_ext << 1) + t_ext;

      if (t11 < LIM4) begin
         ctl_in.piece = eco_pkg::PIECE_FIRST;
         mid          = '0;
      end else if (t11 < LIM8) begin
         ctl_in.piece = eco_pkg::PIECE_SECOND;
         mid          = MID1;
      end else if (t11 < LIM10) begin
         ctl_in.piece = eco_pkg::PIECE_THIRD;
         mid          = MID2;
      end else begin
         ctl_in.piece = eco_pkg::PIECE_FOURTH;
         mid          = MID3;
      end

      span = (t11 >= mid) ? (t11 - mid) : (mid - t11);
      d_in = span[FRAC_BITS+1:0];
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         x_ff   <= x_in;
         d_ff   <= d_in;
         ctl_ff <= ctl_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_d     = d_ff;
   assign out_ctl   = ctl_ff;

endmodule

/* hdl/eco_square.sv */
// Stage 2: square the cube operand and the bounce distance.
`timescale 1ns / 1ps

module eco_square #(
   parameter int FRAC_BITS = eco_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [FRAC_BITS:0]         in_x,
   input  logic [FRAC_BITS+1:0]       in_d,
   input  eco_pkg::ctl_type           in_ctl,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [FRAC_BITS:0]         out_x,
   output logic [2*FRAC_BITS+1:0]     out_xx,
   output logic [2*FRAC_BITS+3:0]     out_sq,
   output eco_pkg::ctl_type           out_ctl
);

   logic                       valid_ff;
   logic [FRAC_BITS:0]         x_ff;
   logic [2*FRAC_BITS+1:0]     xx_ff, xx_in;
   logic [2*FRAC_BITS+3:0]     sq_ff, sq_in;
   eco_pkg::ctl_type           ctl_ff;

   assign xx_in = (2*FRAC_BITS+2)'(in_x) * (2*FRAC_BITS+2)'(in_x);
   assign sq_in = (2*FRAC_BITS+4)'(in_d) * (2*FRAC_BITS+4)'(in_d);

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         x_ff   <= in_x;
         xx_ff  <= xx_in;
         sq_ff  <= sq_in;
         ctl_ff <= in_ctl;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_xx    = xx_ff;
   assign out_sq    = sq_ff;
   assign out_ctl   = ctl_ff;

endmodule

/* hdl/eco_cube.sv */
// Stage 3: round the square, multiply for the cube, finish the bounce piece.
`timescale 1ns / 1ps

module eco_cube #(
   parameter int FRAC_BITS = eco_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [FRAC_BITS:0]         in_x,
   input  logic [2*FRAC_BITS+1:0]     in_xx,
   input  logic [2*FRAC_BITS+3:0]     in_sq,
   input  eco_pkg::ctl_type           in_ctl,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [2*FRAC_BITS+1:0]     out_p,
   output logic [FRAC_BITS:0]         out_bq,
   output eco_pkg::ctl_type           out_ctl
);

   localparam int W  = FRAC_BITS + 1;
   localparam int PW = 2 * FRAC_BITS + 2;
   localparam logic [W-1:0]  ONE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [PW-1:0] RND  = PW'(1) << (FRAC_BITS - 1);

   logic                  valid_ff;
   logic [PW-1:0]         p_ff, p_in;
   logic [W-1:0]          bq_ff, bq_in;
   eco_pkg::ctl_type      ctl_ff;

   logic [PW-1:0]         xx_rnd;
   logic [W-1:0]          sq1;
   logic [FRAC_BITS+1:0]  bsum;
   logic [FRAC_BITS+1:0]  badd;

   always_comb begin
      // Round half up, then the second product of the cube.
      xx_rnd = in_xx + RND;
      sq1    = xx_rnd[FRAC_BITS +: W];
      p_in   = PW'(sq1) * PW'(in_x);

      case (in_ctl.piece)
         eco_pkg::PIECE_SECOND: badd = (FRAC_BITS+2)'(ONE - (ONE >> 2));
         eco_pkg::PIECE_THIRD:  badd = (FRAC_BITS+2)'(ONE - (ONE >> 4));
         eco_pkg::PIECE_FOURTH: badd = (FRAC_BITS+2)'(ONE - (ONE >> 6));
         default:               badd = '0;
      endcase

      bsum  = (FRAC_BITS+2)'(in_sq[FRAC_BITS+4 +: FRAC_BITS])
            + (FRAC_BITS+2)'(in_sq[FRAC_BITS+3]) + badd;
      bq_in = (bsum > (FRAC_BITS+2)'(ONE)) ? ONE : bsum[W-1:0];
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         p_ff   <= p_in;
         bq_ff  <= bq_in;
         ctl_ff <= in_ctl;
      end
   end

   assign out_valid = valid_ff;
   assign out_p     = p_ff;
   assign out_bq    = bq_ff;
   assign out_ctl   = ctl_ff;

endmodule

/* hdl/eco_final.sv */
// Stage 4: round the cube, pick the curve result and clamp it.
`timescale 1ns / 1ps

module eco_final #(
   parameter int FRAC_BITS = eco_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [2*FRAC_BITS+1:0]     in_p,
   input  logic [FRAC_BITS:0]         in_bq,
   input  eco_pkg::ctl_type           in_ctl,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [FRAC_BITS:0]         out_eased
);

   localparam int W  = FRAC_BITS + 1;
   localparam int PW = 2 * FRAC_BITS + 2;
   localparam logic [W-1:0]  ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [PW-1:0] RND = PW'(1) << (FRAC_BITS - 1);

   logic             valid_ff;
   logic [W-1:0]     eased_ff, eased_in;

   logic [PW-1:0]    p_rnd;
   logic [W-1:0]     cube;
   logic [W:0]       half_up;
   logic [W+1:0]     res;

   always_comb begin
      p_rnd   = in_p + RND;
      cube    = p_rnd[FRAC_BITS +: W];
      half_up = ({1'b0, cube} + (W+1)'(1)) >> 1;

      case (in_ctl.func)
         eco_pkg::FUNC_CUBIC_IN:  res = (W+2)'(cube);
         eco_pkg::FUNC_CUBIC_OUT: res = (W+2)'(ONE - cube);
         eco_pkg::FUNC_CUBIC_IN_OUT: begin
            if (in_ctl.hi) begin
               res = (W+2)'(ONE - half_up[W-1:0]);
            end else begin
               res = {cube, 2'b00};
            end
         end
         eco_pkg::FUNC_BOUNCE_OUT: res = (W+2)'(in_bq);
         eco_pkg::FUNC_BOUNCE_IN:  res = (W+2)'(ONE - in_bq);
         default:                  res = '0;
      endcase

      eased_in = (res > (W+2)'(ONE)) ? ONE : res[W-1:0];
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         eased_ff <= eased_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_eased = eased_ff;

endmodule

/* hdl/eco_checker.sv */
// Port-level checks for the easing curve evaluator, bound to the top level.
`timescale 1ns / 1ps

module eco_checker #(
   parameter int FRAC_BITS = eco_pkg::FRAC_BITS_DEFAULT
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [FRAC_BITS:0]   rsp_eased
);

   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // A stalled response stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_eased))
      else $error("response changed while stalled");

   // Results never exceed one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_eased <= ONE)
      else $error("eased value above one");

   // With the output side free the whole pipe can advance.
   assert property (@(posedge clock)
      rsp_ready |-> req_ready)
      else $error("request refused while response side is ready");

   // Nothing is offered straight after a reset cycle.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered after reset");

endmodule

bind easing_curve_evaluator eco_checker #(.FRAC_BITS(FRAC_BITS)) u_eco_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_eased (rsp_eased)
);

/* tb/tb_top.sv */
// Self-checking testbench for the easing curve evaluator: directed, random and stall tests.
`timescale 1ns / 1ps

module tb_top;

   localparam int FRAC = eco_pkg::FRAC_BITS_DEFAULT;
   localparam longint unsigned ONE_Q = 64'd1 << FRAC;
   localparam longint unsigned HALF_Q = ONE_Q >> 1;
   localparam longint unsigned T_MAX = (ONE_Q << 1) - 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;

   // Selector codes with no curve behind them: the block must answer zero.
   localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [2:0] FUNC_SPARE_MID   = 3'd6;
   localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   logic [2:0]      req_func;
   logic [FRAC:0]   req_t;
   logic            rsp_valid;
   logic            rsp_ready;
   logic [FRAC:0]   rsp_eased;

   // One outstanding request and the eased value it must come back with.
   typedef struct {
      logic [2:0]    func;
      logic [FRAC:0] t;
      logic [FRAC:0] eased;
   } eased_due_type;

   eased_due_type eased_due_q[$];

   int fault_count = 0;
   int cycle_count = 0;
   int sink_hold_cycles = 0;
   bit source_idle_on = 1'b1;
   bit sink_idle_on = 1'b1;

   easing_curve_evaluator #(.FRAC_BITS(FRAC)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_t     (req_t),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_eased (rsp_eased)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor: fixed-point curves, products rounded half up.
   // ---------------------------------------------------------------------
   function automatic longint unsigned round_mul(longint unsigned a, longint unsigned b);
      return (a * b + HALF_Q) >> FRAC;
   endfunction

   function automatic longint unsigned cube_q(longint unsigned x);
      return round_mul(round_mul(x, x), x);
   endfunction

   // Four parabolic arcs; thresholds 4/11, 8/11 and 10/11 are tested on 11*p
   // so that no division is needed.
   function automatic longint unsigned bounce_out_q(longint unsigned p);
      longint unsigned p11, centre, lift, gap, sq, v;
      p11 = 11 * p;
      if (p11 < 4 * ONE_Q) begin
         centre = 0;
         lift = 0;
      end else if (p11 < 8 * ONE_Q) begin
         centre = 12 * HALF_Q;
         lift = (3 * ONE_Q) >> 2;
      end else if (p11 < 10 * ONE_Q) begin
         centre = 18 * HALF_Q;
         lift = (15 * ONE_Q) >> 4;
      end else begin
         centre = 21 * HALF_Q;
         lift = (63 * ONE_Q) >> 6;
      end
      gap = (p11 >= centre) ? p11 - centre : centre - p11;
      sq = gap * gap;
      v = (sq >> (FRAC + 4)) + ((sq >> (FRAC + 3)) & 64'd1) + lift;
      return (v > ONE_Q) ? ONE_Q : v;
   endfunction

   function automatic logic [FRAC:0] eased_value(logic [2:0] func, logic [FRAC:0] t);
      longint unsigned p, r, half_cube;
      p = t;
      // Saturate progress beyond one before any curve sees it.
      if (p > ONE_Q)
         p = ONE_Q;
      case (func)
         eco_pkg::FUNC_CUBIC_IN:  r = cube_q(p);
         eco_pkg::FUNC_CUBIC_OUT: r = ONE_Q - cube_q(ONE_Q - p);
         eco_pkg::FUNC_CUBIC_IN_OUT: begin
            if (p < HALF_Q) begin
               r = 4 * cube_q(p);
            end else begin
               half_cube = (cube_q(2 * ONE_Q - 2 * p) + 1) >> 1;
               r = (half_cube > ONE_Q) ? 0 : ONE_Q - half_cube;
            end
         end
         eco_pkg::FUNC_BOUNCE_OUT: r = bounce_out_q(p);
         eco_pkg::FUNC_BOUNCE_IN:  r = ONE_Q - bounce_out_q(ONE_Q - p);
         default:                  r = 0;
      endcase
      if (r > ONE_Q)
         r = ONE_Q;
      return r[FRAC:0];
   endfunction

   // ---------------------------------------------------------------------
   // Random content.
   // ---------------------------------------------------------------------
   function automatic logic [2:0] random_curve();
      if ($urandom_range(0, 9) == 0)
         return 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
      return 3'($urandom_range(eco_pkg::FUNC_CUBIC_IN, eco_pkg::FUNC_BOUNCE_IN));
   endfunction

   // Mostly uniform over 0..1.0, some near the piece boundaries, a few above one.
   function automatic logic [FRAC:0] random_progress();
      int pick;
      longint unsigned pivot;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         return (FRAC + 1)'($urandom_range(ONE_Q + 1, T_MAX));
      if (pick <= 3) begin
         case ($urandom_range(0, 4))
            0:       pivot = HALF_Q;
            1:       pivot = (4 * ONE_Q) / 11;
            2:       pivot = (8 * ONE_Q) / 11;
            3:       pivot = (10 * ONE_Q) / 11;
            default: pivot = ONE_Q;
         endcase
         return (FRAC + 1)'(pivot - 2 + $urandom_range(0, 4));
      end
      return (FRAC + 1)'($urandom_range(0, ONE_Q));
   endfunction

   // ---------------------------------------------------------------------
   // Sender: called at a rising edge, returns at the edge the request is
   // taken. Valid stays high between back-to-back requests; drop it only
   // when an idle burst is inserted.
   // ---------------------------------------------------------------------
   task automatic send_request(input logic [2:0] func, input logic [FRAC:0] t);
      eased_due_type due;
      if (source_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_t <= t;
      do @(posedge clock); while (!req_ready);
      due.func = func;
      due.t = t;
      due.eased = eased_value(func, t);
      eased_due_q.push_back(due);
   endtask

   // ---------------------------------------------------------------------
   // Receiver: ready in random bursts, plus a long hold-off on request.
   // ---------------------------------------------------------------------
   initial begin
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (sink_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (sink_hold_cycles) @(posedge clock);
            sink_hold_cycles = 0;
         end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare every response taken against the oldest outstanding request.
   always @(posedge clock) begin
      eased_due_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (eased_due_q.size() == 0) begin
            fault_count++;
            $display("%0t: response with nothing outstanding: expected none, actual eased=%0d",
                     $time, rsp_eased);
         end else begin
            due = eased_due_q.pop_front();
            if (rsp_eased !== due.eased) begin
               fault_count++;
               $display("%0t: func=%0d t=%0d: expected eased=%0d, actual eased=%0d",
                        $time, due.func, due.t, due.eased, rsp_eased);
            end
         end
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------

   // Both ends of progress on every curve, and either side of one half on in-out.
   task automatic test_curve_extremes();
      logic [2:0] func;
      for (int i = eco_pkg::FUNC_CUBIC_IN; i <= eco_pkg::FUNC_BOUNCE_IN; i++) begin
         func = 3'(i);
         send_request(func, '0);
         send_request(func, (FRAC + 1)'(ONE_Q));
      end
      send_request(eco_pkg::FUNC_CUBIC_IN_OUT, (FRAC + 1)'(HALF_Q - 1));
      send_request(eco_pkg::FUNC_CUBIC_IN_OUT, (FRAC + 1)'(HALF_Q));
   endtask

   // Either side of each bounce piece boundary.
   task automatic test_bounce_boundaries();
      longint unsigned edge_t;
      for (int k = 0; k < 3; k++) begin
         if (k == 0)
            edge_t = (4 * ONE_Q) / 11;
         else if (k == 1)
            edge_t = (8 * ONE_Q) / 11;
         else
            edge_t = (10 * ONE_Q) / 11;
         send_request(eco_pkg::FUNC_BOUNCE_OUT, (FRAC + 1)'(edge_t));
         send_request(eco_pkg::FUNC_BOUNCE_OUT, (FRAC + 1)'(edge_t + 1));
      end
   endtask

   // Progress above one saturates; spare selectors answer zero.
   task automatic test_out_of_range();
      send_request(eco_pkg::FUNC_CUBIC_IN, (FRAC + 1)'(T_MAX));
      send_request(eco_pkg::FUNC_BOUNCE_OUT, (FRAC + 1)'(ONE_Q + 1));
      send_request(FUNC_SPARE_FIRST, (FRAC + 1)'(ONE_Q));
      send_request(FUNC_SPARE_MID, (FRAC + 1)'(1));
      send_request(FUNC_SPARE_LAST, (FRAC + 1)'(T_MAX));
   endtask

   task automatic test_random_mix(input int count);
      for (int i = 0; i < count; i++)
         send_request(random_curve(), random_progress());
   endtask

   // Hold the receiver off while requests keep coming, so the pipeline
   // fills and the input stalls.
   task automatic test_backpressure();
      source_idle_on = 1'b0;
      sink_hold_cycles = 200;
      for (int i = 0; i < 40; i++)
         send_request(random_curve(), random_progress());
      source_idle_on = 1'b1;
   endtask

   // Close with full rate on both sides.
   task automatic test_full_rate(input int count);
      source_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      for (int i = 0; i < count; i++)
         send_request(random_curve(), random_progress());
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= eco_pkg::FUNC_CUBIC_IN;
      req_t <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_curve_extremes();
      test_bounce_boundaries();
      test_out_of_range();
      test_random_mix(600);
      test_backpressure();
      test_full_rate(150);

      // Drop valid, then let the pipeline drain.
      req_valid <= 1'b0;
      while (eased_due_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
